// ----- hdl/ghcb_pkg.sv -----
`timescale 1ns / 1ps

package ghcb_pkg;

    // chunk length limits and field widths
    localparam int LENGTH_LIMIT = 65536;
    localparam int LEN_W        = $clog2(LENGTH_LIMIT + 1);
    localparam int HASH_W       = 32;
    localparam int MASK_W       = 5;
    localparam int BYTE_W       = 8;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_INDEX_W  = 2;
    localparam int GEAR_DEPTH   = 96;
    localparam int GEAR_IDX_W   = $clog2(GEAR_DEPTH);

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] MIN_LENGTH_RST = CFG_DATA_W'(2048);
    localparam logic [CFG_DATA_W-1:0] MAX_LENGTH_RST = CFG_DATA_W'(65536);
    localparam logic [MASK_W-1:0]     MASK_BITS_RST  = MASK_W'(13);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_LENGTH = 2'd0,
        REG_MAX_LENGTH = 2'd1,
        REG_MASK_BITS  = 2'd2
    } cfg_reg_t;

    // configuration as seen by the step logic
    typedef struct packed {
        logic [CFG_DATA_W-1:0] min_length;
        logic [CFG_DATA_W-1:0] max_length;
        logic [MASK_W-1:0]     mask_bits;
    } cfg_t;

    // outcome of one byte
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [LEN_W-1:0]  length;
        logic              ends;
    } step_t;

    // gear table, listed words only; higher byte values map to zero
    localparam logic [HASH_W-1:0] GEAR_LUT [GEAR_DEPTH] = '{
        32'h85e1875e, 32'hd5c7a3d2, 32'h8e6e9a41, 32'hb9f8c673, 32'h3e5a1d4c, 32'h71b2e8f9,
        32'h4a8d3f67, 32'hc2e5a19b, 32'h5f3d7c82, 32'h94a6b1e3, 32'h6d2f4895, 32'he1c7b3a8,
        32'h2b89f4d6, 32'ha73e61c5, 32'h58d4f2b9, 32'hc1e7a384, 32'h96b52d4f, 32'h43a8e761,
        32'h8d2f5c93, 32'hb4e1a7d6, 32'h6f9c3482, 32'he2a5d1b7, 32'h38b4f6e9, 32'h7d1ca543,
        32'h95e2b8f4, 32'h4a67c3d1, 32'hd8f3e5a2, 32'h61b94c87, 32'hb2d4a695, 32'h3e87f1c4,
        32'ha54c2d86, 32'h79e1b3f5, 32'hc6a84d92, 32'h53d7f1e8, 32'h8b42a6c3, 32'h2ef5d917,
        32'ha1c87b34, 32'hd469e2f5, 32'h87b3a1c6, 32'h5e2d94f8, 32'hb1c47a36, 32'h3d8ef2a5,
        32'h69a5c4d7, 32'he2f81b43, 32'h47c3a6d9, 32'h95b2e8f1, 32'h68d4a3c7, 32'hb3e1f5a2,
        32'h2a96c4d8, 32'hd1f5b3a7, 32'h84e2c693, 32'h57a9b3d4, 32'hc8d1e5f6, 32'h3b64a2c9,
        32'h92f7e4b1, 32'h6da5c384, 32'he4b8f1d2, 32'h73a2c5e6, 32'h58d4f1a9, 32'hb6e3c2d7,
        32'h2f95a4c8, 32'ha1d7e3b6, 32'hd8c4f5a2, 32'h47b6e1c3, 32'h93a2d5f4, 32'h65c8b1e7,
        32'he2f4a3d9, 32'h3b87c6a5, 32'h71d9e2f4, 32'ha4c6b5e8, 32'h5e2a3d7f, 32'hc8b1d4e6,
        32'h96f3a2c5, 32'h4d87e1b6, 32'hb5c2f3a8, 32'h27e9d4c1, 32'h6a3f5b82, 32'hd1c4e7a5,
        32'h89b6f2d3, 32'h54e1a3c7, 32'h38f5d9b6, 32'hc2a7e4d8, 32'h7b34c1a5, 32'he6d9f2b3,
        32'h91a5c8e4, 32'h46b7d2f3, 32'hd3e8a5c1, 32'h6a29f4b7, 32'h85c4d6e3, 32'h37b1a9f5,
        32'hb8e2c4d6, 32'h5f93a1c7, 32'hc4d7e6b2, 32'h2a85f3d1, 32'h96e4b7a3, 32'h71c8d5f6
    };

    function automatic logic [HASH_W-1:0] gear_of(input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] word;
        word = '0;
        if (b < BYTE_W'(GEAR_DEPTH))
        begin
            word = GEAR_LUT[b[GEAR_IDX_W-1:0]];
        end
        return word;
    endfunction

endpackage

// ----- hdl/ghcb_step.sv -----
`timescale 1ns / 1ps

module ghcb_step (
    input  ghcb_pkg::cfg_t                 cfg,
    input  logic [ghcb_pkg::HASH_W-1:0]    hash,
    input  logic [ghcb_pkg::LEN_W-1:0]     count,
    input  logic [ghcb_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           stream_end,
    output ghcb_pkg::step_t                step
);
    import ghcb_pkg::*;

    logic [HASH_W-1:0] hash_new;
    logic [HASH_W-1:0] mask;
    logic [LEN_W-1:0]  len;
    logic              hash_hit;
    logic              forced;

    // rolling gear hash update, modulo 2^32
    assign hash_new = {hash[HASH_W-2:0], 1'b0} + gear_of(data_byte);

    // low mask_bits ones; zero width tests nothing
    assign mask = ~({HASH_W{1'b1}} << cfg.mask_bits);

    assign len = count + LEN_W'(1);

    // boundary decision
    assign hash_hit = (len >= LEN_W'(cfg.min_length)) && ((hash_new & mask) == '0);
    assign forced   = (len >= LEN_W'(cfg.max_length)) || (len >= LEN_W'(LENGTH_LIMIT));

    assign step.hash   = hash_new;
    assign step.length = len;
    assign step.ends   = stream_end || forced || hash_hit;

endmodule

// ----- hdl/gear_hash_chunk_boundary.sv -----
`timescale 1ns / 1ps
// throughput: one byte per cycle unless the output stalls; the result is registered
// at input acceptance; hash, length and boundary test settle in one step
// the input side stalls only while a result waits and out_ready is low
// reset (rst_n low, asynchronous): hash and length clear, output goes empty,
// registers return to min_length 2048, max_length 65536, mask_bits 13
module gear_hash_chunk_boundary (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ghcb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ghcb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ghcb_pkg::BYTE_W-1:0]        data_byte,
    input  logic                               stream_end,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ghcb_pkg::BYTE_W-1:0]        byte_out,
    output logic                               chunk_last,
    output logic [ghcb_pkg::LEN_W-1:0]         chunk_length
);
    import ghcb_pkg::*;

    cfg_t              cfg_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [LEN_W-1:0]  length_reg;
    step_t             step;
    logic              in_fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length <= MIN_LENGTH_RST;
            cfg_reg.max_length <= MAX_LENGTH_RST;
            cfg_reg.mask_bits  <= MASK_BITS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_LENGTH: cfg_reg.min_length <= cfg_data;
                REG_MAX_LENGTH: cfg_reg.max_length <= cfg_data;
                REG_MASK_BITS:  cfg_reg.mask_bits  <= cfg_data[MASK_W-1:0];
                default:        ;
            endcase
        end
    end

    // hash and boundary logic for the incoming item
    ghcb_step u_step (
        .cfg        (cfg_reg),
        .hash       (hash_reg),
        .count      (count_reg),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .step       (step)
    );

    // take a new item whenever the output register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // chunk state update
    always_comb
    begin
        hash_next  = hash_reg;
        count_next = count_reg;
        if (in_fire)
        begin
            priority if (stream_end)
            begin
                hash_next  = '0;
                count_next = '0;
            end
            else if (step.ends)
            begin
                hash_next  = step.hash;
                count_next = '0;
            end
            else
            begin
                hash_next  = step.hash;
                count_next = step.length;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg  <= hash_next;
            count_reg <= count_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg   <= data_byte;
            last_reg   <= step.ends;
            length_reg <= step.length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_out     = byte_reg;
    assign chunk_last   = last_reg;
    assign chunk_length = length_reg;

    // the last byte of a stream restarts hash and length
    a_stream_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && stream_end |=> hash_reg == '0 && count_reg == '0)
        else $error("state not cleared after stream end");

    // a chunk never grows past the length limit
    a_limit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_length >= LEN_W'(LENGTH_LIMIT) |-> chunk_last)
        else $error("chunk ran past the length limit");

    // a forwarded item always carries a nonzero length
    a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> chunk_length != '0)
        else $error("zero chunk length on output");

    // open chunk length stays below the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < LEN_W'(LENGTH_LIMIT))
        else $error("open chunk length out of range");

endmodule

// ----- tb/ghcb_checker.sv -----
`timescale 1ns / 1ps

module ghcb_checker
    import ghcb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   stream_end,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [BYTE_W-1:0]      byte_out,
    input  logic                   chunk_last,
    input  logic [LEN_W-1:0]       chunk_length,
    output int                     errors,
    output int                     pending,
    output int                     bytes_checked,
    output int                     chunk_ends
);

    // one marked byte as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              last;
        logic [LEN_W-1:0]  length;
    } chunk_mark_t;

    // gear words for byte values 0..95; all higher values add nothing
    localparam logic [31:0] GEAR_WORDS [96] = '{
        32'h85e1875e, 32'hd5c7a3d2, 32'h8e6e9a41, 32'hb9f8c673, 32'h3e5a1d4c, 32'h71b2e8f9,
        32'h4a8d3f67, 32'hc2e5a19b, 32'h5f3d7c82, 32'h94a6b1e3, 32'h6d2f4895, 32'he1c7b3a8,
        32'h2b89f4d6, 32'ha73e61c5, 32'h58d4f2b9, 32'hc1e7a384, 32'h96b52d4f, 32'h43a8e761,
        32'h8d2f5c93, 32'hb4e1a7d6, 32'h6f9c3482, 32'he2a5d1b7, 32'h38b4f6e9, 32'h7d1ca543,
        32'h95e2b8f4, 32'h4a67c3d1, 32'hd8f3e5a2, 32'h61b94c87, 32'hb2d4a695, 32'h3e87f1c4,
        32'ha54c2d86, 32'h79e1b3f5, 32'hc6a84d92, 32'h53d7f1e8, 32'h8b42a6c3, 32'h2ef5d917,
        32'ha1c87b34, 32'hd469e2f5, 32'h87b3a1c6, 32'h5e2d94f8, 32'hb1c47a36, 32'h3d8ef2a5,
        32'h69a5c4d7, 32'he2f81b43, 32'h47c3a6d9, 32'h95b2e8f1, 32'h68d4a3c7, 32'hb3e1f5a2,
        32'h2a96c4d8, 32'hd1f5b3a7, 32'h84e2c693, 32'h57a9b3d4, 32'hc8d1e5f6, 32'h3b64a2c9,
        32'h92f7e4b1, 32'h6da5c384, 32'he4b8f1d2, 32'h73a2c5e6, 32'h58d4f1a9, 32'hb6e3c2d7,
        32'h2f95a4c8, 32'ha1d7e3b6, 32'hd8c4f5a2, 32'h47b6e1c3, 32'h93a2d5f4, 32'h65c8b1e7,
        32'he2f4a3d9, 32'h3b87c6a5, 32'h71d9e2f4, 32'ha4c6b5e8, 32'h5e2a3d7f, 32'hc8b1d4e6,
        32'h96f3a2c5, 32'h4d87e1b6, 32'hb5c2f3a8, 32'h27e9d4c1, 32'h6a3f5b82, 32'hd1c4e7a5,
        32'h89b6f2d3, 32'h54e1a3c7, 32'h38f5d9b6, 32'hc2a7e4d8, 32'h7b34c1a5, 32'he6d9f2b3,
        32'h91a5c8e4, 32'h46b7d2f3, 32'hd3e8a5c1, 32'h6a29f4b7, 32'h85c4d6e3, 32'h37b1a9f5,
        32'hb8e2c4d6, 32'h5f93a1c7, 32'hc4d7e6b2, 32'h2a85f3d1, 32'h96e4b7a3, 32'h71c8d5f6
    };

    // mirrored registers and rolling state
    logic [CFG_DATA_W-1:0] min_len_q;
    logic [CFG_DATA_W-1:0] max_len_q;
    logic [MASK_W-1:0]     mask_bits_q;
    logic [HASH_W-1:0]     hash_q;
    logic [LEN_W-1:0]      open_len_q;

    chunk_mark_t marks_due[$];
    int fail_count = 0;
    int checked_count = 0;
    int end_count = 0;

    // roll the hash over one byte, decide the boundary, queue the mark
    task automatic mark_byte(input logic [BYTE_W-1:0] b, input logic last_b);
        chunk_mark_t m;
        logic [HASH_W-1:0] word;
        logic [HASH_W-1:0] low_mask;
        logic [LEN_W-1:0]  len;
        logic              ends;
        word = (b < 8'd96) ? GEAR_WORDS[b[6:0]] : '0;
        hash_q = (hash_q << 1) + word;
        len = open_len_q + 1'b1;
        low_mask = (mask_bits_q == '0) ? '0 : ((32'd1 << mask_bits_q) - 32'd1);
        ends = last_b
            || (len >= max_len_q)
            || (int'(len) >= LENGTH_LIMIT)
            || ((len >= min_len_q) && ((hash_q & low_mask) == '0));
        m.byte_val = b;
        m.last = ends;
        m.length = len;
        marks_due.push_back(m);
        // stream end restarts everything, other ends only the length
        if (last_b)
        begin
            hash_q = '0;
            open_len_q = '0;
        end
        else if (ends)
        begin
            open_len_q = '0;
        end
        else
        begin
            open_len_q = len;
        end
    endtask

    // compare one leaving item with the oldest mark
    task automatic compare_mark();
        chunk_mark_t want;
        if (marks_due.size() == 0)
        begin
            $error("byte_out %0d (chunk_last %0d, chunk_length %0d) with no byte outstanding",
                byte_out, chunk_last, chunk_length);
            fail_count++;
        end
        else
        begin
            want = marks_due.pop_front();
            checked_count++;
            if (want.last)
            begin
                end_count++;
            end
            if (byte_out !== want.byte_val)
            begin
                $error("byte_out: expected %0d, got %0d", want.byte_val, byte_out);
                fail_count++;
            end
            if (chunk_last !== want.last)
            begin
                $error("chunk_last: expected %0d, got %0d", want.last, chunk_last);
                fail_count++;
            end
            if (chunk_length !== want.length)
            begin
                $error("chunk_length: expected %0d, got %0d", want.length, chunk_length);
                fail_count++;
            end
        end
    endtask

    // results leave before this edge's byte joins the queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_q = 17'd2048;
            max_len_q = 17'd65536;
            mask_bits_q = 5'd13;
            hash_q = '0;
            open_len_q = '0;
            marks_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                compare_mark();
            end
            if (in_valid && in_ready)
            begin
                mark_byte(data_byte, stream_end);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MIN_LENGTH: min_len_q = cfg_data;
                    REG_MAX_LENGTH: max_len_q = cfg_data;
                    REG_MASK_BITS:  mask_bits_q = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
        pending <= marks_due.size();
        errors <= fail_count;
        bytes_checked <= checked_count;
        chunk_ends <= end_count;
    end

endmodule

// ----- tb/gear_hash_chunk_boundary_tb.sv -----
`timescale 1ns / 1ps

module gear_hash_chunk_boundary_tb;
    import ghcb_pkg::*;

    localparam int PHASE_BYTES   = 250;
    localparam int RANDOM_PHASES = 7;
    localparam int HOLD_CYCLES   = 80;

    // byte mixes for random streams
    typedef enum int {
        MIX_ANY   = 0,
        MIX_TABLE = 1,
        MIX_HIGH  = 2
    } byte_mix_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [BYTE_W-1:0]      data_byte;
    logic                   stream_end;
    logic                   out_valid;
    logic                   out_ready;
    logic [BYTE_W-1:0]      byte_out;
    logic                   chunk_last;
    logic [LEN_W-1:0]       chunk_length;

    int errors;
    int pending;
    int bytes_checked;
    int chunk_ends;
    int settings_loaded;
    int holds_done;
    int stall_left;
    logic hold_req;
    logic src_quiet;
    logic sink_quiet;

    gear_hash_chunk_boundary dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .stream_end   (stream_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_out     (byte_out),
        .chunk_last   (chunk_last),
        .chunk_length (chunk_length)
    );

    ghcb_checker mark_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .stream_end    (stream_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_out      (byte_out),
        .chunk_last    (chunk_last),
        .chunk_length  (chunk_length),
        .errors        (errors),
        .pending       (pending),
        .bytes_checked (bytes_checked),
        .chunk_ends    (chunk_ends)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(10_000_000);
        $display("gear_hash_chunk_boundary_tb: errors");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte(input byte_mix_t mix);
        case (mix)
            MIX_ANY:   return 8'($urandom_range(0, 255));
            MIX_TABLE: return 8'($urandom_range(0, 95));
            default:
            begin
                // runs of zero-weight bytes drain the hash toward zero
                if ($urandom_range(0, 7) == 0)
                begin
                    return 8'($urandom_range(0, 95));
                end
                return 8'($urandom_range(96, 255));
            end
        endcase
    endfunction

    // receiver: random stalls plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req <= 1'b0;
                out_ready <= 1'b0;
                holds_done++;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = sink_quiet ? 0 : idle_gap();
            end
        end
    end

    // offer one item and wait for it to be taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last_b);
        int gap;
        in_valid <= 1'b1;
        data_byte <= b;
        stream_end <= last_b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        gap = src_quiet ? 0 : idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_stream(input int len, input byte_mix_t mix);
        for (int i = 0; i < len; i++)
        begin
            send_byte(pick_byte(mix), (i == len - 1));
        end
    endtask

    // stop offering and wait until every marked byte has left
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // write all three registers back to back; mask upper data bits are junk
    task automatic load_settings(input logic [CFG_DATA_W-1:0] min_v,
                                 input logic [CFG_DATA_W-1:0] max_v,
                                 input logic [MASK_W-1:0]     mask_v);
        cfg_write <= 1'b1;
        cfg_index <= REG_MIN_LENGTH;
        cfg_data <= min_v;
        @(posedge clk);
        cfg_index <= REG_MAX_LENGTH;
        cfg_data <= max_v;
        @(posedge clk);
        cfg_index <= REG_MASK_BITS;
        cfg_data <= {12'($urandom), mask_v};
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    // random streams up to the byte budget of one phase
    task automatic run_phase(input int budget);
        int sent;
        int len;
        int roll;
        sent = 0;
        while (sent < budget)
        begin
            roll = int'($urandom_range(0, 99));
            if (roll < 80)
            begin
                len = int'($urandom_range(1, 40));
            end
            else if (roll < 95)
            begin
                len = int'($urandom_range(41, 200));
            end
            else
            begin
                len = int'($urandom_range(200, 600));
            end
            if (len > budget - sent)
            begin
                len = budget - sent;
            end
            send_stream(len, byte_mix_t'($urandom_range(0, 2)));
            sent += len;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_MIN_LENGTH;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        stream_end = 1'b0;
        hold_req = 1'b0;
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
        settings_loaded = 0;
        holds_done = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: byte extremes, table edge, stream end
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'd95, 1'b0);
        send_byte(8'd96, 1'b1);
        drain();

        // zero maximum: every byte ends a chunk
        load_settings(17'd0, 17'd0, 5'd0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'h01, 1'b1);
        drain();

        // zero mask width: every byte past the minimum ends a chunk
        load_settings(17'd0, 17'h1ffff, 5'd0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h80, 1'b1);
        drain();

        // minimum above maximum: forced end still at the maximum
        load_settings(17'd5, 17'd3, 5'd4);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h40, 1'b1);
        drain();

        // short minimum, one mask bit: hash window spans earlier chunks
        load_settings(17'd0, 17'd65536, 5'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h60, 1'b0);
        send_byte(8'hff, 1'b1);
        drain();

        // random phases over a spread of settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: load_settings(17'd32, 17'd32, 5'd1);
                1: load_settings(17'd65536, 17'd65536, 5'd31);
                2: load_settings(17'($urandom_range(0, 64)), 17'($urandom_range(0, 256)),
                                 5'($urandom_range(0, 10)));
                3: load_settings(17'($urandom_range(64, 600)), 17'($urandom_range(100, 2000)),
                                 5'($urandom_range(2, 12)));
                4: load_settings(17'($urandom_range(100, 400)), 17'($urandom_range(0, 80)),
                                 5'($urandom_range(1, 6)));
                5: load_settings(17'd0, 17'h1ffff, 5'($urandom_range(3, 8)));
                default: load_settings(17'($urandom), 17'($urandom), 5'($urandom));
            endcase
            src_quiet = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            // back the block up while the sender keeps offering
            if (phase == 2 || phase == 5)
            begin
                sink_quiet = 1'b0;
                hold_req <= 1'b1;
            end
            run_phase(PHASE_BYTES);
            drain();
        end

        repeat (5) @(posedge clk);
        $display("covered %0d bytes, %0d chunk ends, %0d register settings",
            bytes_checked, chunk_ends, settings_loaded);
        $display("including %0d long receiver hold-offs against a busy sender",
            holds_done);
        if (errors == 0)
        begin
            $display("gear_hash_chunk_boundary_tb: clean");
        end
        else
        begin
            $display("gear_hash_chunk_boundary_tb: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ghcb_pkg.sv
hdl/ghcb_step.sv
hdl/gear_hash_chunk_boundary.sv
tb/ghcb_checker.sv
tb/gear_hash_chunk_boundary_tb.sv
